### hdl/lcs_pkg.sv
// Package with the shared types, constants and codes of the LRU cache set.
`default_nettype none

package lcs_pkg;

  // Geometry of the set.
  localparam int unsigned Ways    = 8;
  localparam int unsigned TagBits = 32;

  // Widths of the ports, fixed by the transaction format.
  localparam int unsigned PortTagW = 32;
  localparam int unsigned StateW   = 3;
  localparam int unsigned CmdW     = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef enum logic [StateW-1:0] {
    ST_I = 3'd0,
    ST_S = 3'd1,
    ST_E = 3'd2,
    ST_M = 3'd3,
    ST_O = 3'd4,
    ST_F = 3'd5
  } state_e;

  typedef logic [TagBits-1:0] tag_t;

  // Position 0 is LRU, position Ways-1 is MRU.
  typedef logic   [Ways-1:0][TagBits-1:0] tag_arr_t;
  typedef state_e [Ways-1:0]              state_arr_t;

  // Result of the tag compare, handed from the match logic to the update logic.
  typedef struct packed {
    logic            hit;       // at least one valid way matches
    logic [Ways-1:0] first_oh;  // one-hot position of the match nearest LRU
    logic [Ways-1:0] at_or_up;  // positions at or above the first match
    tag_t            sel_tag;   // tag of the first match
    state_e          sel_state; // state of the first match
  } match_t;

  // Codes above F have no meaning and count as Invalid.
  function automatic state_e clean_state(logic [StateW-1:0] raw);
    state_e res;
    if (raw > StateW'(ST_F)) begin
      res = ST_I;
    end else begin
      res = state_e'(raw);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/lru_cache_set_with_coherence_state.sv
// Top level of one true-LRU cache set with per-way coherence state.
// A transaction accepted into the input register is carried out when it moves on into the
// result register, which offers its result on the outputs; it waits while that register is full and not taken.
// One transaction per cycle while the outputs are taken; the tag compare of all ways, the LRU shift
// and the state write happen together, from the input register, when the transaction moves on.
// Reset: asynchronous, active low; all ways become Invalid with zero tags, both
// pipeline stages become empty.
`default_nettype none

module lru_cache_set_with_coherence_state (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [lcs_pkg::CmdW-1:0]     cmd_i,
  input  wire  [lcs_pkg::PortTagW-1:0] tag_i,
  input  wire  [lcs_pkg::StateW-1:0]   new_state_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [lcs_pkg::StateW-1:0]   line_state_o,
  output logic [lcs_pkg::PortTagW-1:0] evicted_tag_o,
  output logic [lcs_pkg::StateW-1:0]   evicted_state_o
);
  import lcs_pkg::*;

  // Input register. The tag is cut to the tag width and unknown state codes
  // are folded to Invalid before they are stored.
  logic   in_valid_q;
  cmd_e   cmd_q;
  tag_t   tag_q;
  state_e ns_q;

  // The set itself, kept in recency order (position 0 is LRU).
  tag_arr_t   tags_q, tags_d;
  state_arr_t states_q, states_d;

  // Result register.
  logic   out_valid_q;
  state_e line_state_q, line_state_d;
  tag_t   ev_tag_q, ev_tag_d;
  state_e ev_state_q, ev_state_d;

  match_t match;
  logic   advance;
  logic   in_take;

  // The stored transaction moves on whenever the result register is empty
  // or its transaction leaves in this cycle; the input register refills at
  // the same edge.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_e'(cmd_i);
      tag_q <= tag_t'(tag_i);
      ns_q  <= clean_state(new_state_i);
    end
  end

  lcs_match u_match (
    .tag_i    (tag_q),
    .tags_i   (tags_q),
    .states_i (states_q),
    .match_o  (match)
  );

  lcs_update u_update (
    .cmd_i        (cmd_q),
    .tag_i        (tag_q),
    .new_state_i  (ns_q),
    .tags_i       (tags_q),
    .states_i     (states_q),
    .match_i      (match),
    .tags_o       (tags_d),
    .states_o     (states_d),
    .line_state_o (line_state_d),
    .ev_tag_o     (ev_tag_d),
    .ev_state_o   (ev_state_d)
  );

  // The set changes only when a transaction is carried out, so a stalled
  // transaction is never applied twice.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tags_q   <= '0;
      states_q <= '{default: ST_I};
    end else if (advance) begin
      tags_q   <= tags_d;
      states_q <= states_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      line_state_q <= line_state_d;
      ev_tag_q     <= ev_tag_d;
      ev_state_q   <= ev_state_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_state_o    = line_state_q;
  assign evicted_tag_o   = PortTagW'(ev_tag_q);
  assign evicted_state_o = ev_state_q;

  // The input side only stalls behind a full result register that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // An insert puts the new block at MRU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_INSERT) |=>
      (tags_q[Ways-1] == $past(tag_q) && states_q[Ways-1] == $past(ns_q)))
    else $error("inserted block not at MRU");

  // A touch that hits leaves a valid way at MRU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_TOUCH && match.hit) |=> (states_q[Ways-1] != ST_I))
    else $error("touched way not at MRU");

  // Invalidating a way leaves an empty way at LRU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_SET && match.hit && ns_q == ST_I) |=>
      (states_q[0] == ST_I && tags_q[0] == '0))
    else $error("invalidated way not at LRU");

  // A lookup reports a valid state only when some way matched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_LOOKUP && !match.hit) |=> (line_state_q == ST_I))
    else $error("lookup miss reported a valid state");

endmodule

`default_nettype wire

### hdl/lcs_match.sv
// Parallel tag compare of all ways with a priority pick toward LRU.
`default_nettype none

module lcs_match (
  input  lcs_pkg::tag_t       tag_i,
  input  lcs_pkg::tag_arr_t   tags_i,
  input  lcs_pkg::state_arr_t states_i,
  output lcs_pkg::match_t     match_o
);
  import lcs_pkg::*;

  logic [Ways-1:0] hit_vec;
  logic [Ways-1:0] seen;

  always_comb begin
    match_o = '0;
    seen    = '0;
    for (int unsigned i = 0; i < Ways; i++) begin
      hit_vec[i] = (states_i[i] != ST_I) && (tags_i[i] == tag_i);
    end
    for (int unsigned i = 0; i < Ways; i++) begin
      if (i == 0) begin
        seen[i] = hit_vec[i];
        match_o.first_oh[i] = hit_vec[i];
      end else begin
        seen[i] = seen[i-1] | hit_vec[i];
        match_o.first_oh[i] = hit_vec[i] & ~seen[i-1];
      end
    end
    match_o.at_or_up = seen;
    match_o.hit      = seen[Ways-1];
    for (int unsigned i = 0; i < Ways; i++) begin
      if (match_o.first_oh[i]) begin
        match_o.sel_tag   = match_o.sel_tag | tags_i[i];
        match_o.sel_state = state_e'(match_o.sel_state | states_i[i]);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/lcs_update.sv
// Next contents of the set and the result fields for one transaction.
`default_nettype none

module lcs_update (
  input  lcs_pkg::cmd_e       cmd_i,
  input  lcs_pkg::tag_t       tag_i,
  input  lcs_pkg::state_e     new_state_i,
  input  lcs_pkg::tag_arr_t   tags_i,
  input  lcs_pkg::state_arr_t states_i,
  input  lcs_pkg::match_t     match_i,
  output lcs_pkg::tag_arr_t   tags_o,
  output lcs_pkg::state_arr_t states_o,
  output lcs_pkg::state_e     line_state_o,
  output lcs_pkg::tag_t       ev_tag_o,
  output lcs_pkg::state_e     ev_state_o
);
  import lcs_pkg::*;

  // Copies of the set moved one place toward LRU and toward MRU.
  // The vacated end fills with zero, which is an empty Invalid way.
  tag_arr_t   tags_lru;
  tag_arr_t   tags_mru;
  state_arr_t states_lru;
  state_arr_t states_mru;
  logic       at_or_below;

  assign tags_lru   = tag_arr_t'(tags_i >> TagBits);
  assign tags_mru   = tag_arr_t'(tags_i << TagBits);
  assign states_lru = state_arr_t'(states_i >> StateW);
  assign states_mru = state_arr_t'(states_i << StateW);

  always_comb begin
    tags_o       = tags_i;
    states_o     = states_i;
    line_state_o = ST_I;
    ev_tag_o     = '0;
    ev_state_o   = ST_I;
    at_or_below  = 1'b0;
    case (cmd_i)
      CMD_LOOKUP: begin
        if (match_i.hit) begin
          line_state_o = match_i.sel_state;
        end
      end
      CMD_TOUCH: begin
        if (match_i.hit) begin
          for (int unsigned i = 0; i < Ways; i++) begin
            if (i == Ways - 1) begin
              tags_o[i]   = match_i.sel_tag;
              states_o[i] = match_i.sel_state;
            end else if (match_i.at_or_up[i]) begin
              tags_o[i]   = tags_lru[i];
              states_o[i] = states_lru[i];
            end
          end
        end
      end
      CMD_INSERT: begin
        ev_tag_o   = tags_i[0];
        ev_state_o = states_i[0];
        tags_o     = tags_lru;
        states_o   = states_lru;
        tags_o[Ways-1]   = tag_i;
        states_o[Ways-1] = new_state_i;
      end
      CMD_SET: begin
        if (match_i.hit) begin
          for (int unsigned i = 0; i < Ways; i++) begin
            at_or_below = ~match_i.at_or_up[i] | match_i.first_oh[i];
            if (new_state_i == ST_I) begin
              if (at_or_below) begin
                tags_o[i]   = tags_mru[i];
                states_o[i] = states_mru[i];
              end
            end else if (match_i.first_oh[i]) begin
              states_o[i] = new_state_i;
            end
          end
        end
      end
      default: begin
        tags_o = tags_i;
      end
    endcase
  end

endmodule

`default_nettype wire
